### rtl/core/palette_lookup_or_add_defines.svh
// Assertion macros used by the palette top module, palette_lookup_or_add.
// Each macro expects clk and rst to be visible in the scope where it is used.
`ifndef PALETTE_LOOKUP_OR_ADD_DEFINES_SVH
`define PALETTE_LOOKUP_OR_ADD_DEFINES_SVH

// Same-cycle implication.
`define PAL_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define PAL_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/core/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

  localparam int CMD_W    = 2;
  localparam int COLOR_W  = 32;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MATCHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_WRITE,
    S_RDREQ,
    S_RDWAIT,
    S_EMIT
  } pal_state_t;

  typedef enum logic [1:0] {
    ASEL_IDX,
    ASEL_REQ,
    ASEL_EMPTY
  } pal_asel_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_MATCH,
    RES_ADD,
    RES_FULL,
    RES_WRITE,
    RES_READ,
    RES_NOP
  } pal_res_t;

  typedef struct packed {
    logic      in_rdy;
    logic      idx_clr;
    logic      idx_inc;
    logic      scan_en;
    logic      ram_we;
    logic      wr_zero;
    pal_asel_t asel;
    pal_res_t  res_op;
    logic      out_load;
  } pal_ctl_t;

  typedef struct packed {
    logic hit;
    logic cmp_last;
    logic idx_last;
    logic empty_any;
    logic addr_ok;
    logic out_free;
  } pal_stat_t;

endpackage

### rtl/core/pal_ram.sv
`timescale 1ns / 1ps

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/core/pal_ctrl.sv
`timescale 1ns / 1ps

module pal_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_fire,
  input  logic [pal_pkg::CMD_W-1:0] command,
  input  pal_pkg::pal_stat_t        stat,
  output pal_pkg::pal_ctl_t         ctl
);

  import pal_pkg::*;

  pal_state_t state;
  pal_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.idx_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (command)
            CMD_LOOKUP: state_next = S_SCAN;
            CMD_WRITE:  state_next = S_WRITE;
            CMD_READ:   state_next = S_RDREQ;
            default:    state_next = S_EMIT;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_EMIT;
        end else if (stat.cmp_last) begin
          state_next = stat.empty_any ? S_ADD : S_EMIT;
        end
      end
      S_ADD:    state_next = S_EMIT;
      S_WRITE:  state_next = S_EMIT;
      S_RDREQ:  state_next = S_RDWAIT;
      S_RDWAIT: state_next = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '{in_rdy: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0, scan_en: 1'b0, ram_we: 1'b0,
            wr_zero: 1'b0, asel: ASEL_IDX, res_op: RES_NONE, out_load: 1'b0};
    case (state)
      S_CLEAR: begin
        ctl.ram_we  = 1'b1;
        ctl.wr_zero = 1'b1;
        ctl.idx_inc = 1'b1;
        if (stat.idx_last) begin
          ctl.idx_clr = 1'b1;
        end
      end
      S_IDLE: begin
        ctl.in_rdy = 1'b1;
        if (in_fire) begin
          case (command)
            CMD_LOOKUP: ctl.idx_clr = 1'b1;
            CMD_WRITE:  ctl.res_op  = RES_NONE;
            CMD_READ:   ctl.res_op  = RES_NONE;
            default:    ctl.res_op  = RES_NOP;
          endcase
        end
      end
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        ctl.idx_inc = 1'b1;
        if (stat.hit) begin
          ctl.res_op = RES_MATCH;
        end else if (stat.cmp_last && !stat.empty_any) begin
          ctl.res_op = RES_FULL;
        end
      end
      S_ADD: begin
        ctl.ram_we = 1'b1;
        ctl.asel   = ASEL_EMPTY;
        ctl.res_op = RES_ADD;
      end
      S_WRITE: begin
        ctl.ram_we = stat.addr_ok;
        ctl.asel   = ASEL_REQ;
        ctl.res_op = RES_WRITE;
      end
      S_RDREQ: begin
        ctl.asel = ASEL_REQ;
      end
      S_RDWAIT: begin
        ctl.res_op = RES_READ;
      end
      S_EMIT: begin
        ctl.out_load = stat.out_free;
      end
      default: begin
        ctl.in_rdy = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/palette_lookup_or_add.sv
`timescale 1ns / 1ps
// Palette of PALETTE_ENTRIES 32-bit colors with lookup-or-add, write and read
// requests, one result per request. After reset a clearing pass zeroes the
// whole store, during which in_ready stays low. A single comparator walks the
// store one slot per cycle through the registered read port of the palette
// memory; a lookup ends at the first match, or after the last slot, when the
// color is added to an empty slot or the table is reported full. A result is
// loaded only once the output register is free, so a stalled output delays
// it. One request is in progress at a time; a new request is taken while the
// previous result still waits at the output.
`include "palette_lookup_or_add_defines.svh"

module palette_lookup_or_add #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pal_pkg::CMD_W-1:0]    command,
  input  logic [pal_pkg::COLOR_W-1:0]  color,
  input  logic [pal_pkg::SLOT_W-1:0]   entry_slot,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pal_pkg::SLOT_W-1:0]   slot,
  output logic [pal_pkg::STATUS_W-1:0] status,
  output logic [pal_pkg::COLOR_W-1:0]  entry_value
);

  import pal_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_ENTRIES - 1);

  pal_ctl_t  ctl;
  pal_stat_t stat;
  logic      in_fire;

  logic [COLOR_W-1:0] color_q;
  logic [SLOT_W-1:0]  addr_q;
  logic               addr_ok;

  logic [AW-1:0]      idx;
  logic               issue_done;
  logic [AW-1:0]      cmp_idx;
  logic               cmp_vld;
  logic               empty_found;
  logic [AW-1:0]      empty_idx;
  logic               hit;
  logic               empty_now;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [COLOR_W-1:0] ram_rdata;

  logic [SLOT_W-1:0]   res_slot;
  logic [STATUS_W-1:0] res_status;
  logic [COLOR_W-1:0]  res_value;

  assign in_ready = ctl.in_rdy;
  assign in_fire  = in_valid && in_ready;
  assign addr_ok  = 32'(addr_q) < PALETTE_ENTRIES;

  pal_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .command (command),
    .stat    (stat),
    .ctl     (ctl)
  );

  always_comb begin
    case (ctl.asel)
      ASEL_REQ:   ram_addr = AW'(32'(addr_q));
      ASEL_EMPTY: ram_addr = empty_idx;
      default:    ram_addr = idx;
    endcase
  end

  assign ram_we    = ctl.ram_we;
  assign ram_wdata = ctl.wr_zero ? '0 : color_q;

  pal_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      color_q <= color;
      addr_q  <= entry_slot;
    end
  end

  assign hit       = cmp_vld && (ram_rdata == color_q);
  assign empty_now = cmp_vld && (ram_rdata == '0) && (cmp_idx != '0) && !empty_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      issue_done  <= 1'b0;
      cmp_vld     <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      if (ctl.idx_clr) begin
        idx         <= '0;
        issue_done  <= 1'b0;
        cmp_vld     <= 1'b0;
        empty_found <= 1'b0;
      end else begin
        cmp_vld <= ctl.scan_en && !issue_done;
        if (ctl.idx_inc) begin
          if (idx == LAST_IDX) begin
            issue_done <= 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        if (ctl.scan_en && empty_now) begin
          empty_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= idx;
    if (ctl.scan_en && empty_now) begin
      empty_idx <= cmp_idx;
    end
  end

  assign stat = '{hit: hit, cmp_last: cmp_vld && (cmp_idx == LAST_IDX),
                  idx_last: idx == LAST_IDX, empty_any: empty_found || empty_now,
                  addr_ok: addr_ok, out_free: !out_valid || out_ready};

  always_ff @(posedge clk) begin
    case (ctl.res_op)
      RES_MATCH: begin
        res_slot   <= SLOT_W'(cmp_idx);
        res_status <= ST_MATCHED;
        res_value  <= '0;
      end
      RES_ADD: begin
        res_slot   <= SLOT_W'(empty_idx);
        res_status <= ST_ADDED;
        res_value  <= '0;
      end
      RES_FULL: begin
        res_slot   <= SLOT_W'(PALETTE_ENTRIES - 1);
        res_status <= ST_FULL;
        res_value  <= '0;
      end
      RES_WRITE: begin
        res_slot   <= addr_q;
        res_status <= ST_DONE;
        res_value  <= '0;
      end
      RES_READ: begin
        res_slot   <= addr_q;
        res_status <= ST_DONE;
        res_value  <= addr_ok ? ram_rdata : '0;
      end
      RES_NOP: begin
        res_slot   <= '0;
        res_status <= ST_DONE;
        res_value  <= '0;
      end
      default: begin
        res_slot   <= res_slot;
        res_status <= res_status;
        res_value  <= res_value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      slot        <= res_slot;
      status      <= res_status;
      entry_value <= res_value;
    end
  end

  `PAL_ASSERT_IMP(a_out_no_overwrite, ctl.out_load, !out_valid || out_ready, "result overwritten")
  `PAL_ASSERT_IMP(a_idle_no_write, in_ready, !ram_we, "palette written while idle")
  `PAL_ASSERT_IMP(a_add_not_slot0, ctl.res_op == RES_ADD, empty_idx != '0, "add into slot zero")
  `PAL_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "ready right after accept")

endmodule
